[hw/rtl/lpgi_pkg.sv]
// Shared types, widths, constants and a rounding helper function for the lidar point grid indexer.
package lpgi_pkg;

    localparam int POS_W     = 16;
    localparam int LAYER_W   = 8;
    localparam int ANG_W     = 19;
    localparam int CPR_W     = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 10;
    localparam int CELL_W    = 13;

    localparam int XY_W      = 35;
    localparam int Z_W       = 20;
    localparam int SPAN_W    = 20;
    localparam int DIFF_W    = 21;
    localparam int PROD_W    = 46;
    localparam int FRAC_W    = 28;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int ATAN_LEN  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL0_ANGLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_PER_RAD = 2'd2;

    localparam logic signed [ANG_W-1:0] START_ANGLE_RST = 19'sd57191;
    localparam logic signed [ANG_W-1:0] COL0_ANGLE_RST  = -19'sd68629;
    localparam logic [CPR_W-1:0]        CPR_RST         = 24'd1877467;

    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;

    // round(atan(2^-i) * 65536)
    localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        20'd51472, 20'd30386, 20'd16055, 20'd8150, 20'd4091, 20'd2047, 20'd1024, 20'd512,
        20'd256,   20'd128,   20'd64,    20'd32,   20'd16,   20'd8,    20'd4,    20'd2,
        20'd1,     20'd0,     20'd0,     20'd0,    20'd0,    20'd0,    20'd0,    20'd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [LAYER_W-1:0]     layer;
        logic                   origin;
    } cordic_t;

    typedef struct packed {
        logic             neg;
        logic [RND_W-1:0] mag;
    } rnd_t;

    // Q28 to integer, halves away from zero, kept as sign and magnitude
    function automatic rnd_t round_q28(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] s;
        rnd_t              r;
        a     = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        s     = a + (PROD_W'(1) << (FRAC_W - 1));
        r.neg = p[PROD_W-1];
        r.mag = s[PROD_W-1:FRAC_W];
        return r;
    endfunction

endpackage

[hw/rtl/lidar_point_grid_index.sv]
// Top level: maps a lidar point to its row, column and cell of an organized angular grid.
//
//  channel  direction  handshake                payload
//  in       request    in_valid / in_ready      pos_x, pos_y, scan_layer
//  out      result     out_valid / out_ready    grid_row, grid_column, cell_index, in_range
//  cfg      write      cfg_wen                  cfg_index, cfg_data
//
//  One point per cycle while the output is not stalled. The pipeline is one input
//  stage, one register per CORDIC iteration, then offset, multiply, round and check.
//  Each stage holds its own valid bit; a stall fills bubbles before it stops the input.
//  Reset clears the valid bits and loads the default scan geometry.
//  Grid width follows a configuration write through the product and width registers.
module lidar_point_grid_index
    import lpgi_pkg::*;
#(
    parameter int LAYERS       = 8,
    parameter int MAX_COLUMNS  = 1024,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic [LAYER_W-1:0]      scan_layer,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ROW_W-1:0]        grid_row,
    output logic [COL_W-1:0]        grid_column,
    output logic [CELL_W-1:0]       cell_index,
    output logic                    in_range,
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int WW = $clog2(MAX_COLUMNS + 1);

    logic signed [ANG_W-1:0]  start_angle_reg;
    logic signed [ANG_W-1:0]  col0_angle_reg;
    logic [CPR_W-1:0]         cpr_reg;
    logic signed [SPAN_W-1:0] span;
    logic signed [PROD_W-1:0] width_prod_reg;
    logic signed [PROD_W-1:0] width_prod_next;
    rnd_t                     width_rnd;
    logic [WW-1:0]            width_reg;
    logic [WW-1:0]            width_next;

    logic    c_valid [CORDIC_STEPS+1];
    logic    c_ready [CORDIC_STEPS+1];
    cordic_t c_data  [CORDIC_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= START_ANGLE_RST;
            col0_angle_reg  <= COL0_ANGLE_RST;
            cpr_reg         <= CPR_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_START_ANGLE:  start_angle_reg <= cfg_data[ANG_W-1:0];
                CFG_COL0_ANGLE:   col0_angle_reg  <= cfg_data[ANG_W-1:0];
                CFG_COLS_PER_RAD: cpr_reg         <= cfg_data[CPR_W-1:0];
                default:          ;
            endcase
        end
    end

    // grid width from the scan span
    assign span            = SPAN_W'(start_angle_reg) - SPAN_W'(col0_angle_reg);
    assign width_prod_next = span * $signed({1'b0, cpr_reg});
    assign width_rnd       = round_q28(width_prod_reg);

    always_comb
    begin
        if (width_rnd.neg)
            width_next = (width_rnd.mag == '0) ? WW'(1) : '0;
        else if (width_rnd.mag >= RND_W'(MAX_COLUMNS))
            width_next = WW'(MAX_COLUMNS);
        else
            width_next = WW'(width_rnd.mag) + WW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_prod_reg <= '0;
            width_reg      <= '0;
        end
        else
        begin
            width_prod_reg <= width_prod_next;
            width_reg      <= width_next;
        end
    end

    lpgi_prerot u_prerot (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .scan_layer (scan_layer),
        .dn_valid   (c_valid[0]),
        .dn_ready   (c_ready[0]),
        .dn_data    (c_data[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        lpgi_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (c_valid[g]),
            .up_ready (c_ready[g]),
            .up_data  (c_data[g]),
            .dn_valid (c_valid[g+1]),
            .dn_ready (c_ready[g+1]),
            .dn_data  (c_data[g+1])
        );
    end

    lpgi_scale #(
        .LAYERS      (LAYERS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_scale (
        .clk                (clk),
        .rst_n              (rst_n),
        .up_valid           (c_valid[CORDIC_STEPS]),
        .up_ready           (c_ready[CORDIC_STEPS]),
        .up_data            (c_data[CORDIC_STEPS]),
        .col0_angle         (col0_angle_reg),
        .columns_per_radian (cpr_reg),
        .width              (width_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .grid_row           (grid_row),
        .grid_column        (grid_column),
        .cell_index         (cell_index),
        .in_range           (in_range)
    );

    // input only backs up when the whole pipe is full behind a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_range) |-> (grid_row == '0 && grid_column == '0 && cell_index == '0))
        else $error("out-of-range result carries nonzero fields");

    a_width_limit: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg <= WW'(MAX_COLUMNS))
        else $error("grid width above limit");

endmodule

[hw/rtl/lpgi_prerot.sv]
// Input stage: scales the point and folds the left half plane by a quarter turn.
module lpgi_prerot
    import lpgi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic [LAYER_W-1:0]      scan_layer,
    output logic                    dn_valid,
    input  logic                    dn_ready,
    output cordic_t                 dn_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        xs = {{(XY_W-POS_W-16){pos_x[POS_W-1]}}, pos_x, 16'b0};
        ys = {{(XY_W-POS_W-16){pos_y[POS_W-1]}}, pos_y, 16'b0};
        data_next.layer  = scan_layer;
        data_next.origin = (pos_x == '0) && (pos_y == '0);
        if (!pos_x[POS_W-1])
        begin
            data_next.x = xs;
            data_next.y = ys;
            data_next.z = '0;
        end
        else if (!pos_y[POS_W-1])
        begin
            data_next.x = ys;
            data_next.y = -xs;
            data_next.z = HALF_PI_Q16;
        end
        else
        begin
            data_next.x = -ys;
            data_next.y = xs;
            data_next.z = -HALF_PI_Q16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

endmodule

[hw/rtl/lpgi_cordic_stage.sv]
// One vectoring CORDIC iteration with its own pipeline register.
module lpgi_cordic_stage
    import lpgi_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_ready,
    input  cordic_t up_data,
    output logic    dn_valid,
    input  logic    dn_ready,
    output cordic_t dn_data
);

    localparam logic signed [Z_W-1:0] ATAN = $signed(ATAN_TAB[SHIFT]);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    logic signed [XY_W-1:0] xi;
    logic signed [XY_W-1:0] yi;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        xi = up_data.x;
        yi = up_data.y;
        dx = yi >>> SHIFT;
        dy = xi >>> SHIFT;
        data_next.layer  = up_data.layer;
        data_next.origin = up_data.origin;
        if (!yi[XY_W-1])
        begin
            data_next.x = xi + dx;
            data_next.y = yi - dy;
            data_next.z = up_data.z + ATAN;
        end
        else
        begin
            data_next.x = xi - dx;
            data_next.y = yi + dy;
            data_next.z = up_data.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

endmodule

[hw/rtl/lpgi_scale.sv]
// Angle to column: offset, multiply, round, then range check and cell address.
module lpgi_scale
    import lpgi_pkg::*;
#(
    parameter int LAYERS      = 8,
    parameter int MAX_COLUMNS = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_ready,
    input  cordic_t                 up_data,
    input  logic signed [ANG_W-1:0] col0_angle,
    input  logic [CPR_W-1:0]        columns_per_radian,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0] width,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ROW_W-1:0]        grid_row,
    output logic [COL_W-1:0]        grid_column,
    output logic [CELL_W-1:0]       cell_index,
    output logic                    in_range
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] rdy;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic [LAYER_W-1:0]       layer_d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [LAYER_W-1:0]       layer_m_reg;
    rnd_t                     rnd_reg;
    logic [LAYER_W-1:0]       layer_r_reg;

    logic              ok;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CELL_W-1:0] cell_reg;
    logic [CELL_W-1:0] cell_next;
    logic              ok_reg;

    assign rdy[NSTG-1] = !v_reg[NSTG-1] || out_ready;
    assign rdy[2]      = !v_reg[2] || rdy[3];
    assign rdy[1]      = !v_reg[1] || rdy[2];
    assign rdy[0]      = !v_reg[0] || rdy[1];
    assign up_ready    = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= up_valid;
            if (rdy[1])
                v_reg[1] <= v_reg[0];
            if (rdy[2])
                v_reg[2] <= v_reg[1];
            if (rdy[3])
                v_reg[3] <= v_reg[2];
        end
    end

    // offset from column zero; the origin point has angle zero
    always_comb
    begin
        if (up_data.origin)
            diff_next = -DIFF_W'(col0_angle);
        else
            diff_next = DIFF_W'(up_data.z) - DIFF_W'(col0_angle);
    end

    assign prod_next = diff_reg * $signed({1'b0, columns_per_radian});

    always_comb
    begin
        ok = (!rnd_reg.neg || (rnd_reg.mag == '0))
             && (rnd_reg.mag < RND_W'(width))
             && (layer_r_reg < LAYER_W'(LAYERS));
        row_next  = ok ? layer_r_reg[ROW_W-1:0] : '0;
        col_next  = ok ? rnd_reg.mag[COL_W-1:0] : '0;
        cell_next = ok ? CELL_W'(CELL_W'(layer_r_reg) * CELL_W'(width) + CELL_W'(rnd_reg.mag))
                       : '0;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && rdy[0])
        begin
            diff_reg    <= diff_next;
            layer_d_reg <= up_data.layer;
        end
        if (v_reg[0] && rdy[1])
        begin
            prod_reg    <= prod_next;
            layer_m_reg <= layer_d_reg;
        end
        if (v_reg[1] && rdy[2])
        begin
            rnd_reg     <= round_q28(prod_reg);
            layer_r_reg <= layer_m_reg;
        end
        if (v_reg[2] && rdy[3])
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            cell_reg <= cell_next;
            ok_reg   <= ok;
        end
    end

    assign out_valid   = v_reg[NSTG-1];
    assign grid_row    = row_reg;
    assign grid_column = col_reg;
    assign cell_index  = cell_reg;
    assign in_range    = ok_reg;

endmodule

[tb/tb.sv]
// Testbench for lidar_point_grid_index: predicts row, column and cell for each point and checks every result.
`timescale 1ns / 1ps

module tb;
    import lpgi_pkg::*;

    localparam int     GRID_ROWS     = 8;
    localparam int     GRID_COLS_MAX = 1024;
    localparam int     CORDIC_ITERS  = 16;
    localparam int     PIPE_LAT      = CORDIC_ITERS + 5;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam longint HALF_PI       = 102944;
    localparam longint ANGLE_MAX     = 205887;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint ARCTAN_Q16 [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] addr;
        logic              hit;
    } grid_cell_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic signed [POS_W-1:0] pos_x       = '0;
    logic signed [POS_W-1:0] pos_y       = '0;
    logic [LAYER_W-1:0]      scan_layer  = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [ROW_W-1:0]        grid_row;
    logic [COL_W-1:0]        grid_column;
    logic [CELL_W-1:0]       cell_index;
    logic                    in_range;
    logic                    cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_W-1:0]        cfg_data    = '0;

    longint     geo_start = 57191;
    longint     geo_end   = -68629;
    longint     geo_cpr   = 1877467;
    grid_cell_t pending_cells [$];
    int         err_count     = 0;
    int         cycle_count   = 0;
    bit         sender_idle_en = 1'b1;
    bit         sink_idle_en   = 1'b1;

    lidar_point_grid_index i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .scan_layer  (scan_layer),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .grid_row    (grid_row),
        .grid_column (grid_column),
        .cell_index  (cell_index),
        .in_range    (in_range),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint point_angle(longint x, longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q16[i];
            end
        end
        return z;
    endfunction

    // Q28 to integer, halves away from zero
    function automatic longint q28_to_int(longint p);
        longint mag;
        longint r;
        mag = (p < 0) ? -p : p;
        r   = (mag + (64'sd1 <<< 27)) >>> 28;
        return (p < 0) ? -r : r;
    endfunction

    function automatic grid_cell_t predict_cell(longint x, longint y, longint layer);
        longint     width;
        longint     col;
        grid_cell_t c;
        width = q28_to_int((geo_start - geo_end) * geo_cpr) + 1;
        if (width < 0)
            width = 0;
        if (width > GRID_COLS_MAX)
            width = GRID_COLS_MAX;
        col = q28_to_int((point_angle(x, y) - geo_end) * geo_cpr);
        c   = '0;
        if (col >= 0 && col < width && layer < GRID_ROWS)
        begin
            c.row  = ROW_W'(layer);
            c.col  = COL_W'(col);
            c.addr = CELL_W'(layer * width + col);
            c.hit  = 1'b1;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // one request; in_valid stays high into the next request when no gap is drawn
    task automatic send_point(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                              input logic [LAYER_W-1:0] layer);
        while (sender_idle_en && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pos_x      <= x;
        pos_y      <= y;
        scan_layer <= layer;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_cells.push_back(predict_cell(longint'(x), longint'(y), longint'(layer)));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_START_ANGLE:  geo_start = longint'(signed'(data[ANG_W-1:0]));
            CFG_COL0_ANGLE:   geo_end   = longint'(signed'(data[ANG_W-1:0]));
            CFG_COLS_PER_RAD: geo_cpr   = longint'(data[CPR_W-1:0]);
            default:          ;
        endcase
    endtask

    task automatic set_geometry(input longint start_a, input longint end_a, input longint cpr);
        logic [ANG_W-1:0] s;
        logic [ANG_W-1:0] e;
        s = ANG_W'(start_a);
        e = ANG_W'(end_a);
        drain_results();
        repeat (PIPE_LAT) @(posedge clk);
        // upper data bits above the angle width must be ignored
        write_reg(CFG_START_ANGLE, {5'($urandom), s});
        write_reg(CFG_COL0_ANGLE, {5'($urandom), e});
        write_reg(CFG_COLS_PER_RAD, CFG_W'(cpr));
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        cfg_wen <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    task automatic send_random_point();
        int                      sel;
        int                      xp;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [LAYER_W-1:0]      layer;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            xp = $urandom_range(1, 32767);
            x  = POS_W'(xp);
            y  = POS_W'(int'($urandom_range(0, 2 * xp)) - xp);
        end
        else if (sel < 75)
        begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
        end
        else if (sel < 90)
        begin
            x = POS_W'(int'($urandom_range(0, 16)) - 8);
            y = POS_W'(int'($urandom_range(0, 16)) - 8);
        end
        else
        begin
            x = POS_W'($urandom);
            y = '0;
            if ($urandom_range(1))
            begin
                y = x;
                x = '0;
            end
        end
        sel = $urandom_range(99);
        if (sel < 80)
            layer = LAYER_W'($urandom_range(0, GRID_ROWS - 1));
        else if (sel < 90)
            layer = LAYER_W'($urandom_range(GRID_ROWS, 255));
        else
            layer = LAYER_W'($urandom);
        send_point(x, y, layer);
    endtask

    task automatic random_geometry(input bit wide_cpr);
        longint s;
        longint e;
        longint c;
        if ($urandom_range(99) < 75)
        begin
            e = -longint'($urandom_range(0, ANGLE_MAX));
            s = longint'($urandom_range(0, ANGLE_MAX));
        end
        else
        begin
            e = longint'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
            s = longint'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
        end
        if (wide_cpr)
            c = longint'($urandom_range(1, 24'hFFFFFF));
        else
            c = longint'($urandom_range(4096, 4096 * 300));
        set_geometry(s, e, c);
    endtask

    task automatic test_reset_geometry();
        send_point(0, 0, 0);
        send_point(-100, 0, 1);
        send_point(100, 0, 2);
        send_point(1000, -1732, 3);
        send_point(1000, 1192, 4);
        send_point(1000, -1760, 5);
        send_point(1000, 1220, 6);
        send_point(32767, 32767, 7);
        send_point(-32768, -32768, 0);
        send_point(-32768, 32767, 1);
        send_point(32767, -32768, 7);
        send_point(0, -5, 2);
        send_point(500, 0, 8);
        send_point(500, 0, 255);
        send_point(0, 32767, 3);
    endtask

    task automatic test_corner_geometry();
        // span negative: width zero
        set_geometry(-ANGLE_MAX, ANGLE_MAX, 24'hFFFFFF);
        send_point(100, 0, 0);
        send_point(-100, 0, 3);
        // full circle at maximum resolution: width saturates
        set_geometry(ANGLE_MAX, -ANGLE_MAX, 24'hFFFFFF);
        send_point(100, 0, 1);
        send_point(-32768, -1, 5);
        send_point(-32768, -20, 6);
        // minimum resolution: one column
        set_geometry(ANGLE_MAX, -ANGLE_MAX, 1);
        send_point(100, 0, 7);
        send_point(-100, 0, 0);
    endtask

    task automatic test_random_geometry();
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_geometry(57191, -68629, 1877467);
            else
                random_geometry(phase == 4);
            for (int n = 0; n < 150; n++)
            begin
                if (phase == 2 && n == 75)
                    drain_results();
                send_random_point();
            end
        end
    endtask

    task automatic test_steady_stream();
        sender_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        random_geometry(1'b0);
        for (int n = 0; n < 150; n++)
            send_random_point();
        sender_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    always @(posedge clk)
    begin
        grid_cell_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
                report_mismatch($sformatf("unexpected result row %0d col %0d cell %0d hit %0b",
                                          grid_row, grid_column, cell_index, in_range));
            else
            begin
                want = pending_cells.pop_front();
                if (grid_row !== want.row || grid_column !== want.col ||
                    cell_index !== want.addr || in_range !== want.hit)
                    report_mismatch($sformatf(
                        "got row %0d col %0d cell %0d hit %0b, want row %0d col %0d cell %0d hit %0b",
                        grid_row, grid_column, cell_index, in_range,
                        want.row, want.col, want.addr, want.hit));
            end
        end
        out_ready <= sink_idle_en ? ($urandom_range(99) >= 35) : 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** lidar_point_grid_index: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_corner_geometry();
        test_random_geometry();
        test_steady_stream();
        drain_results();
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (pending_cells.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_cells.size()));
        if (err_count == 0)
            $display("** lidar_point_grid_index: PASSED **");
        else
            $display("** lidar_point_grid_index: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lpgi_pkg.sv
hw/rtl/lpgi_prerot.sv
hw/rtl/lpgi_cordic_stage.sv
hw/rtl/lpgi_scale.sv
hw/rtl/lidar_point_grid_index.sv
tb/tb.sv
